>>> rtl/cq_keyframe_qp_policy_unit_macros.svh
// Assertion macros for the checker file of the keyframe QP policy block.
`ifndef CQ_KEYFRAME_QP_POLICY_UNIT_MACROS_SVH
`define CQ_KEYFRAME_QP_POLICY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CQKP_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("cqkp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CQKP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("cqkp: next-cycle check failed");

`endif

>>> rtl/cqkp_pkg.sv
// Shared widths, codes, constants and stage type of the keyframe QP policy block.
`default_nettype none

package cqkp_pkg;

    // Field widths
    localparam int FRAME_W    = 32;
    localparam int COST_W     = 24;
    localparam int QPU_W      = 6;
    localparam int QP_W       = 6;
    localparam int BASE_W     = 14;
    localparam int BOOST_W    = 13;
    localparam int THR_W      = 7;
    localparam int INTV_W     = 16;
    localparam int TGT_W      = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int ADJ_WIDTH_DEFAULT = 24;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_QP      = 2'd0,
        REG_KEY_BOOST    = 2'd1,
        REG_COST_THR     = 2'd2,
        REG_KEY_INTERVAL = 2'd3
    } cfg_reg_t;

    // Word modes
    localparam logic MODE_DECIDE   = 1'b0;
    localparam logic MODE_FEEDBACK = 1'b1;

    // Quantizer limits, whole and in hundredths
    localparam int QP_MIN        = 12;
    localparam int QP_MAX        = 48;
    localparam int QP_HUNDREDTHS = 100;
    localparam int QP_MIN_H      = QP_MIN * QP_HUNDREDTHS;
    localparam int QP_MAX_H      = QP_MAX * QP_HUNDREDTHS;
    localparam int ROUND_HALF    = QP_HUNDREDTHS / 2;
    // Sums below the bottom go to QP_MIN, sums at or above the top round to QP_MAX
    localparam int ROUND_LO   = QP_MIN_H + ROUND_HALF;
    localparam int ROUND_HI   = QP_MAX_H - ROUND_HALF;

    // Divide by 100 for values below 4800: (v * 5243) >> 19 is exact
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;

    // Register reset values
    localparam int BASE_RESET     = 2600;
    localparam int BOOST_RESET    = 0;
    localparam int THR_RESET      = 40;
    localparam int INTERVAL_RESET = 250;

    // Decision stage toward the rounding stage
    typedef struct packed {
        logic             valid;
        logic             key;
        logic [TGT_W-1:0] target;
    } stage_t;

endpackage

`default_nettype wire

>>> rtl/cqkp_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface cqkp_in_if;
    import cqkp_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [FRAME_W-1:0] frame_number;
    logic [COST_W-1:0]  intra_metric;
    logic [COST_W-1:0]  inter_metric;
    logic [QPU_W-1:0]   qp_used;

    modport source (
        output valid, mode, frame_number, intra_metric, inter_metric, qp_used,
        input  ready
    );
    modport sink (
        input  valid, mode, frame_number, intra_metric, inter_metric, qp_used,
        output ready
    );
endinterface

interface cqkp_out_if;
    import cqkp_pkg::*;

    logic            valid;
    logic            ready;
    logic [QP_W-1:0] frame_qp;
    logic            keyframe;

    modport source (
        output valid, frame_qp, keyframe,
        input  ready
    );
    modport sink (
        input  valid, frame_qp, keyframe,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cqkp_policy.sv
// Input register, configuration, keyframe decision, target and adjustment state.
`default_nettype none

module cqkp_policy #(
    parameter int ADJ_WIDTH = cqkp_pkg::ADJ_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cqkp_in_if.sink                          in,
    input  logic                             cfg_we,
    input  logic [cqkp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cqkp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output cqkp_pkg::stage_t                 stage,
    output logic signed [ADJ_WIDTH-1:0]      stage_adj,
    input  logic                             stage_ready
);
    import cqkp_pkg::*;

    localparam int FB_W   = ADJ_WIDTH + 2;
    localparam int LHS_W  = COST_W + 9;
    localparam int KEYT_W = TGT_W + 2;

    localparam logic signed [FB_W-1:0] ADJ_MAX = $signed({3'b000, {(ADJ_WIDTH-1){1'b1}}});
    localparam logic signed [FB_W-1:0] ADJ_MIN = $signed({3'b111, {(ADJ_WIDTH-1){1'b0}}});

    // Clamp a base value to the legal target range
    function automatic logic [TGT_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [TGT_W-1:0] r;
        if (b < BASE_W'(QP_MIN_H))
            r = TGT_W'(QP_MIN_H);
        else if (b > BASE_W'(QP_MAX_H))
            r = TGT_W'(QP_MAX_H);
        else
            r = b[TGT_W-1:0];
        return r;
    endfunction

    // Input register
    logic               a_valid_reg;
    logic               a_mode_reg;
    logic [FRAME_W-1:0] a_frame_reg;
    logic [COST_W-1:0]  a_intra_reg;
    logic [COST_W-1:0]  a_inter_reg;
    logic [QPU_W-1:0]   a_used_reg;

    // Configuration registers
    logic [BASE_W-1:0]         base_reg;
    logic signed [BOOST_W-1:0] boost_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [INTV_W-1:0]         interval_reg;

    // Policy state
    logic [FRAME_W-1:0]          last_key_reg;
    logic [FRAME_W-1:0]          last_key_next;
    logic signed [ADJ_WIDTH-1:0] adj_reg;
    logic signed [ADJ_WIDTH-1:0] adj_next;
    logic [TGT_W-1:0]            target_reg;
    logic [TGT_W-1:0]            target_next;

    // Decision stage register
    stage_t                      b_reg;
    logic signed [ADJ_WIDTH-1:0] b_adj_reg;

    logic b_free;
    logic a_fire;
    logic in_fire;
    logic decide_fire;
    logic fb_fire;

    logic signed [7:0]             thr_weight;
    logic signed [LHS_W-1:0]       cost_lhs;
    logic [COST_W+THR_W-1:0]       cost_rhs;
    logic                          cost_key;
    logic [FRAME_W-1:0]            elapsed;
    logic                          force_key;
    logic                          key;
    logic [TGT_W-1:0]              base_c;
    logic signed [KEYT_W-1:0]      key_t;
    logic [TGT_W-1:0]              key_tc;
    logic [TGT_W-1:0]              used_h;
    logic signed [FB_W-1:0]        fb_sum;

    // Handshake: feedback words never wait on the next stage
    assign b_free      = !b_reg.valid || stage_ready;
    assign a_fire      = a_valid_reg && (a_mode_reg == MODE_FEEDBACK || b_free);
    assign in.ready    = !a_valid_reg || a_fire;
    assign in_fire     = in.valid && in.ready;
    assign decide_fire = a_fire && (a_mode_reg == MODE_DECIDE);
    assign fb_fire     = a_fire && (a_mode_reg == MODE_FEEDBACK);

    // Cost test: intra*(100-thr) >= inter*thr, signed
    assign thr_weight = $signed(8'(QP_HUNDREDTHS) - {1'b0, thr_reg});
    assign cost_lhs   = $signed({1'b0, a_intra_reg}) * thr_weight;
    assign cost_rhs   = a_inter_reg * thr_reg;
    assign cost_key   = cost_lhs >= $signed(LHS_W'(cost_rhs));

    // Forced key on frame zero or elapsed count reaching the interval
    assign elapsed   = a_frame_reg - last_key_reg;
    assign force_key = (a_frame_reg == '0) ||
                       (!elapsed[FRAME_W-1] && (elapsed >= FRAME_W'(interval_reg)));
    assign key       = cost_key || force_key;

    // Target: base, or base minus boost for keyframes, clamped
    assign base_c = clamp_base(base_reg);
    assign key_t  = $signed(KEYT_W'(base_c)) - KEYT_W'(boost_reg);

    always_comb
    begin
        if (key_t < $signed(KEYT_W'(QP_MIN_H)))
            key_tc = TGT_W'(QP_MIN_H);
        else if (key_t > $signed(KEYT_W'(QP_MAX_H)))
            key_tc = TGT_W'(QP_MAX_H);
        else
            key_tc = key_t[TGT_W-1:0];
    end

    // Feedback: saturating add of target minus 100*qp_used
    assign used_h = TGT_W'(a_used_reg * QP_HUNDREDTHS);
    assign fb_sum = FB_W'(adj_reg) + $signed(FB_W'(target_reg)) - $signed(FB_W'(used_h));

    always_comb
    begin
        adj_next = adj_reg;
        if (fb_fire)
        begin
            if (fb_sum > ADJ_MAX)
                adj_next = ADJ_MAX[ADJ_WIDTH-1:0];
            else if (fb_sum < ADJ_MIN)
                adj_next = ADJ_MIN[ADJ_WIDTH-1:0];
            else
                adj_next = fb_sum[ADJ_WIDTH-1:0];
        end
    end

    // Key frame and target updates
    always_comb
    begin
        last_key_next = last_key_reg;
        target_next   = target_reg;
        if (decide_fire)
        begin
            if (key)
                last_key_next = a_frame_reg;
            target_next = key ? key_tc : base_c;
        end
        if (cfg_we && cfg_index == REG_BASE_QP)
            target_next = clamp_base(cfg_data[BASE_W-1:0]);
    end

    // Capture input words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in.ready)
            a_valid_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_mode_reg  <= in.mode;
            a_frame_reg <= in.frame_number;
            a_intra_reg <= in.intra_metric;
            a_inter_reg <= in.inter_metric;
            a_used_reg  <= in.qp_used;
        end
    end

    // Configuration writes and policy state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_W'(BASE_RESET);
            boost_reg    <= BOOST_W'(BOOST_RESET);
            thr_reg      <= THR_W'(THR_RESET);
            interval_reg <= INTV_W'(INTERVAL_RESET);
            last_key_reg <= '0;
            adj_reg      <= '0;
            target_reg   <= TGT_W'(BASE_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_QP:      base_reg     <= cfg_data[BASE_W-1:0];
                    REG_KEY_BOOST:    boost_reg    <= $signed(cfg_data[BOOST_W-1:0]);
                    REG_COST_THR:     thr_reg      <= cfg_data[THR_W-1:0];
                    REG_KEY_INTERVAL: interval_reg <= cfg_data[INTV_W-1:0];
                    default:          ;
                endcase
            end
            last_key_reg <= last_key_next;
            adj_reg      <= adj_next;
            target_reg   <= target_next;
        end
    end

    // Decision stage register: advance when free, load data with a decide word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg     <= '0;
            b_adj_reg <= '0;
        end
        else if (b_free)
        begin
            b_reg.valid <= decide_fire;
            if (decide_fire)
            begin
                b_reg.key    <= key;
                b_reg.target <= target_next;
                b_adj_reg    <= adj_reg;
            end
        end
    end

    assign stage     = b_reg;
    assign stage_adj = b_adj_reg;

endmodule

`default_nettype wire

>>> rtl/cqkp_round.sv
// Rounding of target plus adjustment to a whole clamped QP, and the result register.
`default_nettype none

module cqkp_round #(
    parameter int ADJ_WIDTH = cqkp_pkg::ADJ_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cqkp_pkg::stage_t            stage,
    input  logic signed [ADJ_WIDTH-1:0] stage_adj,
    output logic                        stage_ready,
    cqkp_out_if.source                  out
);
    import cqkp_pkg::*;

    localparam int SUM_W = ADJ_WIDTH + 1;

    logic            o_valid_reg;
    logic [QP_W-1:0] o_qp_reg;
    logic            o_key_reg;

    logic signed [SUM_W-1:0] sum;
    logic [TGT_W-1:0]        rounded;
    logic [2*TGT_W-1:0]      prod;
    logic [QP_W-1:0]         qp;

    // Sum in hundredths
    assign sum = SUM_W'(stage_adj) + $signed(SUM_W'(stage.target));

    // Round half up inside the legal band, then divide by 100
    assign rounded = TGT_W'(sum[TGT_W-1:0] + TGT_W'(ROUND_HALF));
    assign prod    = rounded * TGT_W'(RECIP);

    always_comb
    begin
        if (sum < $signed(SUM_W'(ROUND_LO)))
            qp = QP_W'(QP_MIN);
        else if (sum >= $signed(SUM_W'(ROUND_HI)))
            qp = QP_W'(QP_MAX);
        else
            qp = prod[RECIP_SHIFT +: QP_W];
    end

    // Result register
    assign stage_ready = !o_valid_reg || out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (stage_ready)
            o_valid_reg <= stage.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && stage.valid)
        begin
            o_qp_reg  <= qp;
            o_key_reg <= stage.key;
        end
    end

    assign out.valid    = o_valid_reg;
    assign out.frame_qp = o_qp_reg;
    assign out.keyframe = o_key_reg;

endmodule

`default_nettype wire

>>> rtl/cq_keyframe_qp_policy_unit.sv
// Top level of the constant-quality keyframe and quantizer policy block.
`default_nettype none

// Each decide word (mode 0) yields one result word with the frame quantizer (12..48) and
// a keyframe flag; a feedback word (mode 1) folds target minus 100*qp_used into a
// saturating adjustment and yields nothing. Words are taken one per cycle, sustained,
// with stalls only when the result register is full and not taken. A decide word
// passes the input register, then the decision register (cost multipliers, keyframe
// test, target clamp and state update), then the result register behind the rounding
// multiply. Feedback leaves after the decision step, so a decide that follows it sees
// the new adjustment. Write configuration only while idle; writing the base register
// also reloads the current target.
module cq_keyframe_qp_policy_unit #(
    parameter int ADJ_WIDTH = cqkp_pkg::ADJ_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cqkp_in_if.sink                         in,
    cqkp_out_if.source                      out,
    input  logic                            cfg_we,
    input  logic [cqkp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cqkp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cqkp_pkg::*;

    stage_t                      stage;
    logic signed [ADJ_WIDTH-1:0] stage_adj;
    logic                        stage_ready;

    // Decision and state
    cqkp_policy #(
        .ADJ_WIDTH (ADJ_WIDTH)
    ) u_policy (
        .clk         (clk),
        .rst_n       (rst_n),
        .in          (in),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stage       (stage),
        .stage_adj   (stage_adj),
        .stage_ready (stage_ready)
    );

    // Rounding and result word
    cqkp_round #(
        .ADJ_WIDTH (ADJ_WIDTH)
    ) u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .stage_adj   (stage_adj),
        .stage_ready (stage_ready),
        .out         (out)
    );

endmodule

`default_nettype wire

>>> rtl/cqkp_checker.sv
// Port-level checks of the keyframe QP policy block, bound to its top level.
`default_nettype none

`include "cq_keyframe_qp_policy_unit_macros.svh"

module cqkp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [cqkp_pkg::QP_W-1:0]   frame_qp,
    input wire logic                        keyframe
);
    import cqkp_pkg::*;

    logic qp_in_range;

    assign qp_in_range = (frame_qp >= QP_W'(QP_MIN)) && (frame_qp <= QP_W'(QP_MAX));

    // A shown result always lies in the legal quantizer band
    `CQKP_ASSERT_NOW(a_qp_range, clk, rst_n, out_valid, qp_in_range)

    // With the result register empty the pipe drains, so input is always taken
    `CQKP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // A stalled result word holds its value
    `CQKP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(frame_qp) && $stable(keyframe))

    // No input offered and an empty result register leave the input register free
    `CQKP_ASSERT_NEXT(a_ready_after_drain, clk, rst_n, !out_valid && !in_valid,
        in_ready)

endmodule

bind cq_keyframe_qp_policy_unit cqkp_checker u_cqkp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .frame_qp  (out.frame_qp),
    .keyframe  (out.keyframe)
);

`default_nettype wire
